[src/yuv2rgb_pkg.sv]
`default_nettype none

package yuv2rgb_pkg;

  // Pixels carried by one stream request, and the chroma pairs that go with them.
  localparam int PIXEL_LANES     = 4;
  localparam int CHROMA_PAIRS    = (PIXEL_LANES + 1) / 2;
  localparam int COEFF_FRAC_BITS = 12;

  localparam int SAMPLE_W  = 8;
  localparam int GAIN_W    = 16;
  localparam int OFFSET_W  = 21;
  // Unsigned sample widened with a zero sign bit, times a signed gain.
  localparam int PROD_W    = SAMPLE_W + 1 + GAIN_W;
  // Offset plus up to three products, with headroom.
  localparam int SUM_W     = PROD_W + 3;

  localparam int IN_FIELDS  = PIXEL_LANES + 2 * CHROMA_PAIRS;
  localparam int OUT_FIELDS = 3 * PIXEL_LANES;
  localparam int IN_W       = IN_FIELDS * SAMPLE_W;
  localparam int OUT_W      = OUT_FIELDS * SAMPLE_W;

  // Register file: eight registers, 64-bit data, one per 8 bytes.
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 3;

  localparam logic [REG_IDX_W-1:0] REG_LUMA_GAIN_RED       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHROMA_V_GAIN_RED   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LUMA_GAIN_GREEN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHROMA_U_GAIN_GREEN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CHROMA_V_GAIN_GREEN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LUMA_GAIN_BLUE      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHROMA_U_GAIN_BLUE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_OFFSETS     = 3'd7;

  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Conversion settings shared by all lanes.
  typedef struct packed {
    gain_t   luma_gain_red;
    gain_t   chroma_v_gain_red;
    gain_t   luma_gain_green;
    gain_t   chroma_u_gain_green;
    gain_t   chroma_v_gain_green;
    gain_t   luma_gain_blue;
    gain_t   chroma_u_gain_blue;
    offset_t offset_red;
    offset_t offset_green;
    offset_t offset_blue;
  } cfg_t;

  // Drop the fraction and saturate to one 8-bit channel.
  function automatic logic [SAMPLE_W-1:0] clamp_channel(input sum_t sum);
    logic [SAMPLE_W-1:0] ch;
    if (sum[SUM_W-1]) begin
      ch = '0;
    end else if (|sum[SUM_W-2:COEFF_FRAC_BITS+SAMPLE_W]) begin
      ch = '1;
    end else begin
      ch = sum[COEFF_FRAC_BITS+SAMPLE_W-1:COEFF_FRAC_BITS];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[src/yuv2rgb_regs.sv]
`default_nettype none

module yuv2rgb_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [yuv2rgb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [yuv2rgb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [yuv2rgb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                     pready,
  output yuv2rgb_pkg::cfg_t                        cfg
);
  import yuv2rgb_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:3];

  // Register writes; gains keep their low 16 bits, offsets their low 63.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LUMA_GAIN_RED:       cfg.luma_gain_red       <= pwdata[GAIN_W-1:0];
        REG_CHROMA_V_GAIN_RED:   cfg.chroma_v_gain_red   <= pwdata[GAIN_W-1:0];
        REG_LUMA_GAIN_GREEN:     cfg.luma_gain_green     <= pwdata[GAIN_W-1:0];
        REG_CHROMA_U_GAIN_GREEN: cfg.chroma_u_gain_green <= pwdata[GAIN_W-1:0];
        REG_CHROMA_V_GAIN_GREEN: cfg.chroma_v_gain_green <= pwdata[GAIN_W-1:0];
        REG_LUMA_GAIN_BLUE:      cfg.luma_gain_blue      <= pwdata[GAIN_W-1:0];
        REG_CHROMA_U_GAIN_BLUE:  cfg.chroma_u_gain_blue  <= pwdata[GAIN_W-1:0];
        REG_CHANNEL_OFFSETS: begin
          cfg.offset_red   <= pwdata[OFFSET_W-1:0];
          cfg.offset_green <= pwdata[2*OFFSET_W-1:OFFSET_W];
          cfg.offset_blue  <= pwdata[3*OFFSET_W-1:2*OFFSET_W];
        end
        default: ;
      endcase
    end
  end

  // Read back the stored value, zero-extended.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LUMA_GAIN_RED:       prdata[GAIN_W-1:0] = cfg.luma_gain_red;
      REG_CHROMA_V_GAIN_RED:   prdata[GAIN_W-1:0] = cfg.chroma_v_gain_red;
      REG_LUMA_GAIN_GREEN:     prdata[GAIN_W-1:0] = cfg.luma_gain_green;
      REG_CHROMA_U_GAIN_GREEN: prdata[GAIN_W-1:0] = cfg.chroma_u_gain_green;
      REG_CHROMA_V_GAIN_GREEN: prdata[GAIN_W-1:0] = cfg.chroma_v_gain_green;
      REG_LUMA_GAIN_BLUE:      prdata[GAIN_W-1:0] = cfg.luma_gain_blue;
      REG_CHROMA_U_GAIN_BLUE:  prdata[GAIN_W-1:0] = cfg.chroma_u_gain_blue;
      REG_CHANNEL_OFFSETS: begin
        prdata[3*OFFSET_W-1:0] = {cfg.offset_blue, cfg.offset_green, cfg.offset_red};
      end
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/yuv2rgb_lane.sv]
`default_nettype none

module yuv2rgb_lane (
  input  wire logic                              clk,
  input  wire logic                              ld_prod,
  input  wire logic                              ld_sum,
  input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]  luma,
  input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]  chroma_u,
  input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]  chroma_v,
  input  wire yuv2rgb_pkg::cfg_t                 cfg,
  output logic      [yuv2rgb_pkg::SAMPLE_W-1:0]  red,
  output logic      [yuv2rgb_pkg::SAMPLE_W-1:0]  green,
  output logic      [yuv2rgb_pkg::SAMPLE_W-1:0]  blue
);
  import yuv2rgb_pkg::*;

  logic signed [SAMPLE_W:0] y_s;
  logic signed [SAMPLE_W:0] u_s;
  logic signed [SAMPLE_W:0] v_s;

  prod_t p_yr;
  prod_t p_vr;
  prod_t p_yg;
  prod_t p_ug;
  prod_t p_vg;
  prod_t p_yb;
  prod_t p_ub;

  sum_t sum_r;
  sum_t sum_g;
  sum_t sum_b;

  // Samples are unsigned; a zero sign bit keeps the products signed.
  assign y_s = $signed({1'b0, luma});
  assign u_s = $signed({1'b0, chroma_u});
  assign v_s = $signed({1'b0, chroma_v});

  // First stage: one multiplier per term.
  always_ff @(posedge clk) begin
    if (ld_prod) begin
      p_yr <= PROD_W'(y_s) * PROD_W'(cfg.luma_gain_red);
      p_vr <= PROD_W'(v_s) * PROD_W'(cfg.chroma_v_gain_red);
      p_yg <= PROD_W'(y_s) * PROD_W'(cfg.luma_gain_green);
      p_ug <= PROD_W'(u_s) * PROD_W'(cfg.chroma_u_gain_green);
      p_vg <= PROD_W'(v_s) * PROD_W'(cfg.chroma_v_gain_green);
      p_yb <= PROD_W'(y_s) * PROD_W'(cfg.luma_gain_blue);
      p_ub <= PROD_W'(u_s) * PROD_W'(cfg.chroma_u_gain_blue);
    end
  end

  // Second stage: add the channel offset and the products.
  always_comb begin
    sum_r = SUM_W'(cfg.offset_red) + SUM_W'(p_yr) + SUM_W'(p_vr);
    sum_g = SUM_W'(cfg.offset_green) + SUM_W'(p_yg) + SUM_W'(p_ug) + SUM_W'(p_vg);
    sum_b = SUM_W'(cfg.offset_blue) + SUM_W'(p_yb) + SUM_W'(p_ub);
  end

  // Clamped channels are the lane's output register.
  always_ff @(posedge clk) begin
    if (ld_sum) begin
      red   <= clamp_channel(sum_r);
      green <= clamp_channel(sum_g);
      blue  <= clamp_channel(sum_b);
    end
  end

endmodule

`default_nettype wire

[src/yuv420_to_rgb_convert_core.sv]
// Converts four 4:2:0 YUV pixels to RGB per request, one lane per pixel.
// Pipeline: multiply stage, then sum and clamp stage; m_tvalid is the valid of the second.
// One request per cycle unless stalled; each lane has one multiplier per term in its first stage.
// Empty stages fill while the output waits, so up to two requests can be held under backpressure.
// Reset (rst, synchronous) clears the pipeline valids and sets all gains and offsets to zero.
`default_nettype none

module yuv420_to_rgb_convert_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Fields from bit 0 up: luma_0, luma_1, luma_2, luma_3,
  // chroma_u_left, chroma_v_left, chroma_u_right, chroma_v_right.
  input  wire logic [yuv2rgb_pkg::IN_W-1:0]        s_tdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0 up: red_0..red_3, green_0..green_3, blue_0..blue_3.
  output logic      [yuv2rgb_pkg::OUT_W-1:0]       m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [yuv2rgb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [yuv2rgb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [yuv2rgb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                     pready
);
  import yuv2rgb_pkg::*;

  cfg_t cfg;
  logic prod_valid;
  logic out_valid;
  logic ld_prod;
  logic ld_sum;

  yuv2rgb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Each stage loads when it is empty or its contents move on.
  assign ld_sum   = !out_valid || m_tready;
  assign ld_prod  = !prod_valid || ld_sum;
  assign s_tready = ld_prod;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ld_prod) begin
        prod_valid <= s_tvalid;
      end
      if (ld_sum) begin
        out_valid <= prod_valid;
      end
    end
  end

  // One lane per pixel; pixels 2k and 2k+1 share chroma pair k.
  for (genvar k = 0; k < PIXEL_LANES; k++) begin : g_lane
    localparam int U_POS = PIXEL_LANES + 2 * (k / 2);

    yuv2rgb_lane u_lane (
      .clk      (clk),
      .ld_prod  (ld_prod),
      .ld_sum   (ld_sum),
      .luma     (s_tdata[k*SAMPLE_W +: SAMPLE_W]),
      .chroma_u (s_tdata[U_POS*SAMPLE_W +: SAMPLE_W]),
      .chroma_v (s_tdata[(U_POS+1)*SAMPLE_W +: SAMPLE_W]),
      .cfg      (cfg),
      .red      (m_tdata[k*SAMPLE_W +: SAMPLE_W]),
      .green    (m_tdata[(PIXEL_LANES+k)*SAMPLE_W +: SAMPLE_W]),
      .blue     (m_tdata[(2*PIXEL_LANES+k)*SAMPLE_W +: SAMPLE_W])
    );
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import yuv2rgb_pkg::*;

  // Receiver hold-off used to back the pipeline up into its input.
  localparam int LONG_HOLD  = 300;
  // Cycles with no accepted request, result or register write before the run is abandoned.
  localparam int IDLE_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Register shadow used by the color predictor.
  gain_t                  gain_reg [0:6];
  logic [3*OFFSET_W-1:0]  offset_word;

  logic [IN_W-1:0]  yuv_pending [$];
  logic [OUT_W-1:0] rgb_expected [$];

  int   error_count = 0;
  int   quiet_cycles = 0;
  bit   in_accepted = 1'b0;
  bit   out_accepted = 1'b0;
  bit   source_gaps_on = 1'b0;
  bit   sink_gaps_on = 1'b0;
  bit   long_hold_req = 1'b0;
  int   source_gap_left = 0;
  int   sink_stall_left = 0;

  string channel_name [3] = '{"red", "green", "blue"};

  yuv420_to_rgb_convert_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Truncate the fraction and saturate to one 8-bit channel.
  function automatic logic [SAMPLE_W-1:0] saturate_channel(input longint sum);
    longint whole;
    if (sum < 0) begin
      return '0;
    end
    whole = sum >>> COEFF_FRAC_BITS;
    if (whole > 255) begin
      return 8'd255;
    end
    return whole[SAMPLE_W-1:0];
  endfunction

  // Expected RGB for one request; pixels 0-1 use the left chroma pair, 2-3 the right.
  function automatic logic [OUT_W-1:0] predict_rgb(input logic [IN_W-1:0] yuv);
    logic [OUT_W-1:0] rgb;
    offset_t          off;
    longint           off_r, off_g, off_b;
    longint           y, u, v, r, g, b;
    int               pair;
    off = offset_word[OFFSET_W-1:0];
    off_r = longint'(off);
    off = offset_word[2*OFFSET_W-1:OFFSET_W];
    off_g = longint'(off);
    off = offset_word[3*OFFSET_W-1:2*OFFSET_W];
    off_b = longint'(off);
    for (int k = 0; k < PIXEL_LANES; k++) begin
      pair = k / 2;
      y = longint'(yuv[k*SAMPLE_W +: SAMPLE_W]);
      u = longint'(yuv[(PIXEL_LANES + 2*pair)*SAMPLE_W +: SAMPLE_W]);
      v = longint'(yuv[(PIXEL_LANES + 2*pair + 1)*SAMPLE_W +: SAMPLE_W]);
      r = off_r + y * gain_reg[REG_LUMA_GAIN_RED] + v * gain_reg[REG_CHROMA_V_GAIN_RED];
      g = off_g + y * gain_reg[REG_LUMA_GAIN_GREEN] + u * gain_reg[REG_CHROMA_U_GAIN_GREEN]
          + v * gain_reg[REG_CHROMA_V_GAIN_GREEN];
      b = off_b + y * gain_reg[REG_LUMA_GAIN_BLUE] + u * gain_reg[REG_CHROMA_U_GAIN_BLUE];
      rgb[k*SAMPLE_W +: SAMPLE_W]                   = saturate_channel(r);
      rgb[(PIXEL_LANES + k)*SAMPLE_W +: SAMPLE_W]   = saturate_channel(g);
      rgb[(2*PIXEL_LANES + k)*SAMPLE_W +: SAMPLE_W] = saturate_channel(b);
    end
    return rgb;
  endfunction

  // Mostly short gaps, some medium ones and an occasional long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Gains are mostly near unity scale so outputs stay in range, sometimes anything.
  function automatic int pick_gain();
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = $urandom_range(0, 65535);
      return g - 32768;
    end
    g = $urandom_range(0, 12000);
    return g - 6000;
  endfunction

  function automatic int pick_offset();
    int o;
    o = $urandom_range(0, 2097151);
    return o - 1048576;
  endfunction

  // Bytes lean toward the range ends so clamping is hit often.
  function automatic logic [IN_W-1:0] random_yuv();
    logic [IN_W-1:0] yuv;
    int              roll;
    for (int k = 0; k < IN_FIELDS; k++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        yuv[k*SAMPLE_W +: SAMPLE_W] = 8'h00;
      end else if (roll == 1) begin
        yuv[k*SAMPLE_W +: SAMPLE_W] = 8'hFF;
      end else begin
        yuv[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 255));
      end
    end
    return yuv;
  endfunction

  function automatic logic [IN_W-1:0] pack_yuv(input logic [7:0] y0, y1, y2, y3,
                                               input logic [7:0] ul, vl, ur, vr);
    return {vr, ur, vl, ul, y3, y2, y1, y0};
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (idx == REG_CHANNEL_OFFSETS) begin
      offset_word = value[3*OFFSET_W-1:0];
    end else begin
      gain_reg[idx] = value[GAIN_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program every register; bits above each register's width carry junk.
  task automatic set_coeffs(input int luma_r, chroma_v_r, luma_g, chroma_u_g, chroma_v_g,
                            input int luma_b, chroma_u_b, off_r, off_g, off_b);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_LUMA_GAIN_RED,       {junk[63:16], luma_r[15:0]});
    write_reg(REG_CHROMA_V_GAIN_RED,   {junk[47:0], chroma_v_r[15:0]});
    write_reg(REG_LUMA_GAIN_GREEN,     {junk[63:16], luma_g[15:0]});
    write_reg(REG_CHROMA_U_GAIN_GREEN, {junk[31:0], junk[63:48], chroma_u_g[15:0]});
    write_reg(REG_CHROMA_V_GAIN_GREEN, {junk[63:16], chroma_v_g[15:0]});
    write_reg(REG_LUMA_GAIN_BLUE,      {junk[47:0], luma_b[15:0]});
    write_reg(REG_CHROMA_U_GAIN_BLUE,  {junk[63:16], chroma_u_b[15:0]});
    write_reg(REG_CHANNEL_OFFSETS,
              {junk[0], off_b[OFFSET_W-1:0], off_g[OFFSET_W-1:0], off_r[OFFSET_W-1:0]});
  endtask

  // Sender holds back until every request sent so far has come out.
  task automatic wait_drained();
    while (yuv_pending.size() != 0 || s_tvalid || rgb_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Field extremes, bit patterns, and left/right chroma pairs pulled apart.
  task automatic push_corner_items();
    @(posedge clk);
    yuv_pending.push_back('0);
    yuv_pending.push_back('1);
    yuv_pending.push_back(pack_yuv(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    yuv_pending.push_back(pack_yuv(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    yuv_pending.push_back({IN_FIELDS{8'hAA}});
    yuv_pending.push_back({IN_FIELDS{8'h55}});
    yuv_pending.push_back(pack_yuv(8'd128, 8'd128, 8'd128, 8'd128, 8'h00, 8'hFF, 8'hFF, 8'h00));
    yuv_pending.push_back(pack_yuv(8'd128, 8'd128, 8'd128, 8'd128, 8'hFF, 8'h00, 8'h00, 8'hFF));
    for (int f = 0; f < IN_FIELDS; f++) begin
      yuv_pending.push_back({{(IN_W-SAMPLE_W){1'b0}}, 8'hFF} << (f*SAMPLE_W));
    end
  endtask

  task automatic run_batch(input int count, input bit src_gaps, input bit dst_gaps,
                           input bit hold);
    source_gaps_on = src_gaps;
    sink_gaps_on   = dst_gaps;
    @(posedge clk);
    for (int n = 0; n < count; n++) begin
      yuv_pending.push_back(random_yuv());
    end
    if (hold) begin
      long_hold_req = 1'b1;
    end
    wait_drained();
  endtask

  // Request driver: a new request goes out once the current one is taken.
  always @(negedge clk) begin
    if (!s_tvalid || in_accepted) begin
      if (source_gap_left > 0) begin
        s_tvalid <= 1'b0;
        source_gap_left--;
      end else if (yuv_pending.size() != 0) begin
        s_tdata  <= yuv_pending.pop_front();
        s_tvalid <= 1'b1;
        source_gap_left = source_gaps_on ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      sink_stall_left = LONG_HOLD;
      long_hold_req   = 1'b0;
    end
    if (sink_stall_left > 0) begin
      m_tready <= 1'b0;
      sink_stall_left--;
    end else if (sink_gaps_on) begin
      sink_stall_left = pick_gap();
      m_tready <= (sink_stall_left == 0);
      if (sink_stall_left > 0) begin
        sink_stall_left--;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: check results against the oldest prediction, then record new requests.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    in_accepted  = !rst && s_tvalid && s_tready;
    out_accepted = !rst && m_tvalid && m_tready;
    if (out_accepted) begin
      if (rgb_expected.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        error_count++;
      end else begin
        want = rgb_expected.pop_front();
        for (int k = 0; k < OUT_FIELDS; k++) begin
          if (want[k*SAMPLE_W +: SAMPLE_W] !== m_tdata[k*SAMPLE_W +: SAMPLE_W]) begin
            $error("%s_%0d: expected %0d, actual %0d", channel_name[k / PIXEL_LANES],
                   k % PIXEL_LANES, want[k*SAMPLE_W +: SAMPLE_W],
                   m_tdata[k*SAMPLE_W +: SAMPLE_W]);
            error_count++;
          end
        end
      end
    end
    if (in_accepted) begin
      rgb_expected.push_back(predict_rgb(s_tdata));
    end

    // Watchdog on progress of either stream or the register port.
    if (!rst) begin
      if (in_accepted || out_accepted || (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 7; i++) begin
      gain_reg[i] = '0;
    end
    offset_word = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: every channel must come out as zero.
    push_corner_items();
    wait_drained();

    // BT.601 studio range; the blue offset sits at the bottom of its range.
    set_coeffs(4768, 6537, 4768, -1602, -3330, 4768, 8266, -913048, 554959, -1048576);
    source_gaps_on = 1'b1;
    sink_gaps_on   = 1'b1;
    push_corner_items();
    wait_drained();
    run_batch(300, 1'b0, 1'b0, 1'b0);
    run_batch(250, 1'b1, 1'b1, 1'b0);

    // Extreme settings: full positive, full negative, and mixed signs.
    set_coeffs(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1048575, 1048575, 1048575);
    push_corner_items();
    wait_drained();
    run_batch(80, 1'b1, 1'b1, 1'b0);
    set_coeffs(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
               -1048576, -1048576, -1048576);
    push_corner_items();
    wait_drained();
    run_batch(80, 1'b1, 1'b1, 1'b0);
    set_coeffs(32767, -32768, -32768, 32767, 32767, 32767, -32768, -1048576, 1048575, 0);
    run_batch(80, 1'b0, 1'b1, 1'b0);

    // Long receiver hold-off while the sender keeps offering requests.
    set_coeffs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
               pick_gain(), pick_offset(), pick_offset(), pick_offset());
    run_batch(300, 1'b1, 1'b0, 1'b1);

    // Random settings, with gaps switched per phase.
    for (int p = 0; p < 4; p++) begin
      set_coeffs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                 pick_gain(), pick_offset(), pick_offset(), pick_offset());
      run_batch(180, p != 1, p != 2, 1'b0);
    end

    // Let the pipeline settle so a stray result would still be seen.
    repeat (6) @(negedge clk);
    if (error_count == 0 && rgb_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/yuv2rgb_pkg.sv
src/yuv2rgb_regs.sv
src/yuv2rgb_lane.sv
src/yuv420_to_rgb_convert_core.sv
sim/tb_top.sv
